/* rtl/core/bfgl_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Bitmap font glyph lookup package
// Shared constants, command codes, port structs and UTF-8 helper functions.
// ----------------------------------------------------------------------------
package bfgl_pkg;

    // Table sizing.
    localparam int MAX_GLYPHS = 512;
    localparam int IDX_W      = $clog2(MAX_GLYPHS);
    localparam int CNT_W      = $clog2(MAX_GLYPHS + 1);
    localparam int SEL_W      = (IDX_W > 9) ? IDX_W : 9;
    localparam int PROD_W     = SEL_W + 9;

    // Command codes.
    localparam logic [1:0] CMD_TABLE_BYTE = 2'd0;
    localparam logic [1:0] CMD_LOOKUP     = 2'd1;
    localparam logic [1:0] CMD_RESTART    = 2'd2;

    // Register indexes.
    localparam logic [1:0] REG_GLYPH_COUNT = 2'd0;
    localparam logic [1:0] REG_GLYPH_BYTES = 2'd1;
    localparam logic [1:0] REG_TABLE_ON    = 2'd2;

    // Register reset values.
    localparam logic [9:0] RST_GLYPH_COUNT = 10'd256;
    localparam logic [8:0] RST_GLYPH_BYTES = 9'd32;

    // Byte constants.
    localparam logic [7:0]  SEP_BYTE = 8'hFF;
    localparam logic [31:0] ASCII_LO = 32'd32;
    localparam logic [31:0] ASCII_HI = 32'd127;

    // Write port of the entry memory.
    typedef struct packed {
        logic              en;
        logic [IDX_W-1:0]  addr;
        logic [31:0]       data;
    } t_wr_port;

    // Read request to the entry memory.
    typedef struct packed {
        logic              en;
        logic [IDX_W-1:0]  addr;
    } t_rd_req;

    // One lookup result.
    typedef struct packed {
        logic        valid;
        logic        present;
        logic        fallback;
        logic [8:0]  glyph_id;
        logic [16:0] glyph_offset;
        logic [2:0]  bytes_used;
    } t_result;

    // UTF-8 sequence length from the lead byte; invalid leads count as one.
    function automatic logic [2:0] utf8_len(input logic [7:0] lead);
        logic [2:0] len;
        begin
            if (lead[7] == 1'b0) begin
                len = 3'd1;
            end else if (lead[7:5] == 3'b110) begin
                len = 3'd2;
            end else if (lead[7:4] == 4'b1110) begin
                len = 3'd3;
            end else if (lead[7:3] == 5'b11110) begin
                len = 3'd4;
            end else begin
                len = 3'd1;
            end
            return len;
        end
    endfunction

    // Join the first len query bytes big-endian; byte 0 sits in bits 7:0.
    function automatic logic [31:0] utf8_value(input logic [31:0] q, input logic [2:0] len);
        logic [31:0] v;
        begin
            case (len)
                3'd2:    v = {16'd0, q[7:0], q[15:8]};
                3'd3:    v = {8'd0, q[7:0], q[15:8], q[23:16]};
                3'd4:    v = {q[7:0], q[15:8], q[23:16], q[31:24]};
                default: v = {24'd0, q[7:0]};
            endcase
            return v;
        end
    endfunction

    // Effective glyph limit: the smaller of the register and the table size.
    function automatic logic [CNT_W-1:0] glyph_limit(input logic [9:0] gc);
        logic [CNT_W-1:0] lim;
        begin
            if (int'(gc) < MAX_GLYPHS) begin
                lim = CNT_W'(gc);
            end else begin
                lim = CNT_W'(MAX_GLYPHS);
            end
            return lim;
        end
    endfunction

endpackage
`default_nettype wire

/* rtl/core/bfgl_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Entry memory
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module bfgl_ram #(
    parameter int DEPTH = 512,
    parameter int WIDTH = 32
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire [$clog2(DEPTH)-1:0]  i_waddr,
    input  wire [WIDTH-1:0]          i_wdata,
    input  wire                      i_re,
    input  wire [$clog2(DEPTH)-1:0]  i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

/* rtl/core/bfgl_parser.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Unicode table parser
// Takes description bytes, keeps the first UTF-8 value of each glyph and
// writes it to the entry memory; the write index doubles as the fill count.
// ----------------------------------------------------------------------------
module bfgl_parser (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_byte_valid,
    input  wire [7:0]                  i_byte,
    input  wire                        i_restart,
    input  wire [bfgl_pkg::CNT_W-1:0]  i_limit,
    output bfgl_pkg::t_wr_port         o_wr,
    output logic [bfgl_pkg::CNT_W-1:0] o_fill
);

    typedef enum logic [1:0] {
        PH_FIRST,
        PH_CONT,
        PH_SKIP
    } t_phase;

    t_phase                      r_phase, n_phase;
    logic [bfgl_pkg::CNT_W-1:0]  r_windex, n_windex;
    logic [2:0]                  r_needed, n_needed;
    logic [2:0]                  r_taken, n_taken;
    logic [31:0]                 r_partial, n_partial;
    logic [31:0]                 w_joined;
    logic [2:0]                  w_taken_inc;
    logic [2:0]                  w_lead_len;

    assign w_joined    = {r_partial[23:0], i_byte};
    assign w_taken_inc = r_taken + 3'd1;
    assign w_lead_len  = bfgl_pkg::utf8_len(i_byte);

    // Next-state logic of the description parser.
    always_comb begin
        n_phase   = r_phase;
        n_windex  = r_windex;
        n_needed  = r_needed;
        n_taken   = r_taken;
        n_partial = r_partial;
        o_wr.en   = 1'b0;
        o_wr.addr = r_windex[bfgl_pkg::IDX_W-1:0];
        o_wr.data = w_joined;
        if (i_restart) begin
            n_phase   = PH_FIRST;
            n_windex  = '0;
            n_needed  = 3'd0;
            n_taken   = 3'd0;
            n_partial = 32'd0;
        end else if (i_byte_valid) begin
            case (r_phase)
                PH_CONT: begin
                    n_partial = w_joined;
                    n_taken   = w_taken_inc;
                    if (w_taken_inc >= r_needed) begin
                        o_wr.en  = 1'b1;
                        n_windex = r_windex + 1'b1;
                        n_phase  = PH_SKIP;
                    end
                end
                PH_SKIP: begin
                    if (i_byte == bfgl_pkg::SEP_BYTE) begin
                        n_phase = PH_FIRST;
                    end
                end
                PH_FIRST: begin
                    if (r_windex < i_limit) begin
                        n_partial = {24'd0, i_byte};
                        n_needed  = w_lead_len;
                        n_taken   = 3'd1;
                        if (w_lead_len > 3'd1) begin
                            n_phase = PH_CONT;
                        end else begin
                            // Single-byte value; a separator here ends the entry at once.
                            o_wr.en   = 1'b1;
                            o_wr.data = {24'd0, i_byte};
                            n_windex  = r_windex + 1'b1;
                            n_phase   = (i_byte == bfgl_pkg::SEP_BYTE) ? PH_FIRST : PH_SKIP;
                        end
                    end
                end
                default: begin
                    n_phase = PH_FIRST;
                end
            endcase
        end
    end

    // Parser state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_FIRST;
            r_windex  <= '0;
            r_needed  <= 3'd0;
            r_taken   <= 3'd0;
            r_partial <= 32'd0;
        end else begin
            r_phase   <= n_phase;
            r_windex  <= n_windex;
            r_needed  <= n_needed;
            r_taken   <= n_taken;
            r_partial <= n_partial;
        end
    end

    assign o_fill = r_windex;

endmodule
`default_nettype wire

/* rtl/core/bfgl_search.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Glyph search sequencer
// Table mode walks the filled part of the entry memory one entry per cycle through a
// single compare unit, ASCII mode maps the code; then scales the chosen index to a byte offset.
// ----------------------------------------------------------------------------
module bfgl_search (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_go,
    input  wire [31:0]                 i_query_bytes,
    input  wire [bfgl_pkg::CNT_W-1:0]  i_limit,
    input  wire [bfgl_pkg::CNT_W-1:0]  i_fill,
    input  wire                        i_table_on,
    input  wire [8:0]                  i_glyph_bytes,
    input  wire [31:0]                 i_rdata,
    output bfgl_pkg::t_rd_req          o_rd,
    output logic                       o_busy,
    output bfgl_pkg::t_result          o_result
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_MUL
    } t_state;

    t_state                      r_state, n_state;
    logic [31:0]                 r_value, n_value;
    logic [2:0]                  r_len, n_len;
    logic [bfgl_pkg::CNT_W-1:0]  r_end, n_end;
    logic [bfgl_pkg::CNT_W-1:0]  r_addr, n_addr;
    logic                        r_pend, n_pend;
    logic [bfgl_pkg::IDX_W-1:0]  r_pend_addr, n_pend_addr;
    logic [bfgl_pkg::SEL_W-1:0]  r_idx, n_idx;
    logic                        r_hit, n_hit;
    bfgl_pkg::t_result           r_result, n_result;

    logic [2:0]                  w_len;
    logic [31:0]                 w_value;
    logic                        w_rd_en;
    logic [bfgl_pkg::PROD_W-1:0] w_prod;
    logic                        w_present;

    assign w_len   = bfgl_pkg::utf8_len(i_query_bytes[7:0]);
    assign w_value = bfgl_pkg::utf8_value(i_query_bytes, w_len);
    assign w_rd_en = (r_state == S_SCAN) && (r_addr < r_end);

    // Offset multiplier and bound check on the chosen index.
    assign w_prod    = bfgl_pkg::PROD_W'(i_glyph_bytes) * bfgl_pkg::PROD_W'(r_idx);
    assign w_present = {1'b0, r_idx} < (bfgl_pkg::SEL_W + 1)'(i_limit);

    // Sequencer next-state logic.
    always_comb begin
        n_state     = r_state;
        n_value     = r_value;
        n_len       = r_len;
        n_end       = r_end;
        n_addr      = r_addr;
        n_pend      = 1'b0;
        n_pend_addr = r_addr[bfgl_pkg::IDX_W-1:0];
        n_idx       = r_idx;
        n_hit       = r_hit;
        n_result    = r_result;
        n_result.valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_go) begin
                    n_value = w_value;
                    n_len   = w_len;
                    if (i_table_on) begin
                        n_end   = (i_fill < i_limit) ? i_fill : i_limit;
                        n_addr  = '0;
                        n_state = S_SCAN;
                    end else begin
                        // ASCII codes above 32 up to 127 map straight to their code.
                        if ((w_value > bfgl_pkg::ASCII_LO) && (w_value <= bfgl_pkg::ASCII_HI)) begin
                            n_idx = bfgl_pkg::SEL_W'(w_value[6:0]);
                            n_hit = 1'b1;
                        end else begin
                            n_idx = '0;
                            n_hit = 1'b0;
                        end
                        n_state = S_MUL;
                    end
                end
            end
            S_SCAN: begin
                // Issue the next read and compare the data of the previous one.
                n_pend = w_rd_en;
                if (w_rd_en) begin
                    n_addr = r_addr + 1'b1;
                end
                if (r_pend && (i_rdata == r_value)) begin
                    n_idx   = bfgl_pkg::SEL_W'(r_pend_addr);
                    n_hit   = 1'b1;
                    n_pend  = 1'b0;
                    n_state = S_MUL;
                end else if (!w_rd_en && !r_pend) begin
                    n_idx   = '0;
                    n_hit   = 1'b0;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_result.valid        = 1'b1;
                n_result.present      = w_present;
                n_result.fallback     = !r_hit;
                n_result.glyph_id     = 9'(r_idx);
                n_result.glyph_offset = w_present ? 17'(w_prod) : 17'd0;
                n_result.bytes_used   = r_len;
                n_state               = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Sequencer state and registered result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_pend         <= 1'b0;
            r_result.valid <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_pend         <= n_pend;
            r_result.valid <= n_result.valid;
        end
        r_value               <= n_value;
        r_len                 <= n_len;
        r_end                 <= n_end;
        r_addr                <= n_addr;
        r_pend_addr           <= n_pend_addr;
        r_idx                 <= n_idx;
        r_hit                 <= n_hit;
        r_result.present      <= n_result.present;
        r_result.fallback     <= n_result.fallback;
        r_result.glyph_id     <= n_result.glyph_id;
        r_result.glyph_offset <= n_result.glyph_offset;
        r_result.bytes_used   <= n_result.bytes_used;
    end

    assign o_rd.en   = w_rd_en;
    assign o_rd.addr = r_addr[bfgl_pkg::IDX_W-1:0];
    assign o_busy    = (r_state != S_IDLE);
    assign o_result  = r_result;

endmodule
`default_nettype wire

/* rtl/core/bitmap_font_glyph_lookup.sv */
`timescale 1ns / 1ps
`default_nettype none
// Table mode scans entries 0 to N-1, N = min(glyph limit, entries loaded), and stops at the
// first hit; one compare unit reads one entry per cycle. ASCII mode does no scan.
// Busy holds off the next transaction while a lookup is in progress; table-byte, restart
// and unused commands never raise busy and give no result. The receiver cannot stall.
// Reset clears parser, fill count, sequencer and registers, but not the entry memory.
// ----------------------------------------------------------------------------
// Bitmap font glyph lookup
// Builds a unicode-to-glyph table from description bytes and maps UTF-8
// characters to a glyph index and bitmap byte offset.
// ----------------------------------------------------------------------------
module bitmap_font_glyph_lookup (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // Command channel
    input  wire         start,
    output logic        busy,
    input  wire [1:0]   i_command,
    input  wire [7:0]   i_table_byte,
    input  wire [31:0]  i_query_bytes,
    // Result channel
    output logic        o_valid,
    output logic        o_present,
    output logic        o_fallback,
    output logic [8:0]  o_glyph_id,
    output logic [16:0] o_glyph_offset,
    output logic [2:0]  o_bytes_used,
    // Configuration port
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire [3:0]   paddr,
    input  wire [31:0]  pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [9:0]                  r_glyph_count;
    logic [8:0]                  r_glyph_bytes;
    logic                        r_table_on;

    logic                        w_accept;
    logic                        w_cfg_write;
    logic [1:0]                  w_reg_idx;
    logic [bfgl_pkg::CNT_W-1:0]  w_limit;
    logic [bfgl_pkg::CNT_W-1:0]  w_fill;
    logic [31:0]                 w_rdata;
    bfgl_pkg::t_wr_port          w_wr;
    bfgl_pkg::t_rd_req           w_rd;
    bfgl_pkg::t_result           w_result;

    assign w_accept    = start && !busy;
    assign w_cfg_write = psel && penable && pwrite && pready;
    assign w_reg_idx   = paddr[3:2];
    assign w_limit     = bfgl_pkg::glyph_limit(r_glyph_count);
    assign pready      = 1'b1;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_glyph_count <= bfgl_pkg::RST_GLYPH_COUNT;
            r_glyph_bytes <= bfgl_pkg::RST_GLYPH_BYTES;
            r_table_on    <= 1'b1;
        end else if (w_cfg_write) begin
            case (w_reg_idx)
                bfgl_pkg::REG_GLYPH_COUNT: r_glyph_count <= pwdata[9:0];
                bfgl_pkg::REG_GLYPH_BYTES: r_glyph_bytes <= pwdata[8:0];
                bfgl_pkg::REG_TABLE_ON:    r_table_on    <= pwdata[0];
                default: begin
                end
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        case (w_reg_idx)
            bfgl_pkg::REG_GLYPH_COUNT: prdata = {22'd0, r_glyph_count};
            bfgl_pkg::REG_GLYPH_BYTES: prdata = {23'd0, r_glyph_bytes};
            bfgl_pkg::REG_TABLE_ON:    prdata = {31'd0, r_table_on};
            default:                   prdata = 32'd0;
        endcase
    end

    // Description table parser.
    bfgl_parser u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_byte_valid (w_accept && (i_command == bfgl_pkg::CMD_TABLE_BYTE)),
        .i_byte       (i_table_byte),
        .i_restart    (w_accept && (i_command == bfgl_pkg::CMD_RESTART)),
        .i_limit      (w_limit),
        .o_wr         (w_wr),
        .o_fill       (w_fill)
    );

    // Entry memory.
    bfgl_ram #(
        .DEPTH (bfgl_pkg::MAX_GLYPHS),
        .WIDTH (32)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_wr.en),
        .i_waddr (w_wr.addr),
        .i_wdata (w_wr.data),
        .i_re    (w_rd.en),
        .i_raddr (w_rd.addr),
        .o_rdata (w_rdata)
    );

    // Lookup sequencer.
    bfgl_search u_search (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_go          (w_accept && (i_command == bfgl_pkg::CMD_LOOKUP)),
        .i_query_bytes (i_query_bytes),
        .i_limit       (w_limit),
        .i_fill        (w_fill),
        .i_table_on    (r_table_on),
        .i_glyph_bytes (r_glyph_bytes),
        .i_rdata       (w_rdata),
        .o_rd          (w_rd),
        .o_busy        (busy),
        .o_result      (w_result)
    );

    assign o_valid        = w_result.valid;
    assign o_present      = w_result.present;
    assign o_fallback     = w_result.fallback;
    assign o_glyph_id     = w_result.glyph_id;
    assign o_glyph_offset = w_result.glyph_offset;
    assign o_bytes_used   = w_result.bytes_used;

`ifndef SYNTHESIS
    // A result only ends a lookup that was in progress.
    a_result_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result strobe without a lookup in progress");

    // The block only goes busy for an accepted lookup transaction.
    a_busy_from_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> ($past(start) && ($past(i_command) == bfgl_pkg::CMD_LOOKUP)))
        else $error("busy rose without a lookup transaction");

    // A glyph outside the font carries no offset.
    a_absent_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_present) |-> (o_glyph_offset == 17'd0))
        else $error("nonzero offset for an absent glyph");

    // A fallback always selects glyph zero.
    a_fallback_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_fallback) |-> (o_glyph_id == 9'd0))
        else $error("fallback with a nonzero glyph index");
`endif

endmodule
`default_nettype wire

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap font glyph lookup testbench
// Feeds unicode description bytes and UTF-8 lookups through the command
// port, reprograms the font registers over APB between phases, and checks
// every lookup result against a glyph table tracker kept in step with the
// accepted commands.
// ----------------------------------------------------------------------------
module testbench;
    import bfgl_pkg::*;

    // Run limits, in clock cycles.
    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int DRAIN_CYCLES = MAX_GLYPHS + 8;

    // Command code that the block ignores.
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // Parser state of the description loader.
    typedef enum {LOAD_LEAD, LOAD_CONT, LOAD_SKIP} t_load_state;

    // How often the command side pauses.
    typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_BOTH} t_idle_mode;

    // One lookup result as seen on the result ports.
    typedef struct packed {
        logic        present;
        logic        fallback;
        logic [8:0]  index;
        logic [16:0] offset;
        logic [2:0]  used;
    } t_glyph_result;

    // Mirrors the font registers and the unicode table, and holds the lookup
    // results that are still due from the block.
    class glyph_table_tracker;
        bit [9:0]      glyph_count;
        bit [8:0]      glyph_bytes;
        bit            table_on;
        bit [31:0]     entry_value [MAX_GLYPHS];
        bit            entry_valid [MAX_GLYPHS];
        int unsigned   fill_index;
        t_load_state   load_state;
        int unsigned   need;
        int unsigned   taken;
        bit [31:0]     partial;
        t_glyph_result pending_glyphs[$];
        int unsigned   lookups;
        int unsigned   hits;
        int unsigned   absent;
        int unsigned   mismatches;

        function new();
            glyph_count = RST_GLYPH_COUNT;
            glyph_bytes = RST_GLYPH_BYTES;
            table_on    = 1'b1;
            clear_entries();
        endfunction

        function void clear_entries();
            for (int i = 0; i < MAX_GLYPHS; i++) begin
                entry_valid[i] = 1'b0;
                entry_value[i] = '0;
            end
            fill_index = 0;
            load_state = LOAD_LEAD;
            need       = 0;
            taken      = 0;
            partial    = '0;
        endfunction

        // Sequence length implied by a UTF-8 lead byte; bad leads stand alone.
        function int unsigned lead_length(bit [7:0] lead);
            if (lead < 8'h80) return 1;
            if (lead >= 8'hC0 && lead < 8'hE0) return 2;
            if (lead >= 8'hE0 && lead < 8'hF0) return 3;
            if (lead >= 8'hF0 && lead < 8'hF8) return 4;
            return 1;
        endfunction

        function int unsigned glyph_span();
            return (glyph_count < MAX_GLYPHS) ? glyph_count : MAX_GLYPHS;
        endfunction

        function void set_register(logic [1:0] idx, logic [31:0] value);
            case (idx)
                REG_GLYPH_COUNT: glyph_count = value[9:0];
                REG_GLYPH_BYTES: glyph_bytes = value[8:0];
                REG_TABLE_ON:    table_on    = value[0];
                default: ;
            endcase
        endfunction

        function void store_partial();
            if (fill_index < MAX_GLYPHS) begin
                entry_value[fill_index] = partial;
                entry_valid[fill_index] = 1'b1;
            end
            fill_index++;
        endfunction

        // Advance the description parser by one table byte.
        function void absorb_byte(bit [7:0] b);
            if (load_state == LOAD_CONT) begin
                partial = (partial << 8) | b;
                taken++;
                if (taken >= need) begin
                    store_partial();
                    load_state = LOAD_SKIP;
                end
            end else if (load_state == LOAD_SKIP) begin
                if (b == SEP_BYTE) load_state = LOAD_LEAD;
            end else if (fill_index < glyph_span()) begin
                partial = b;
                need    = lead_length(b);
                taken   = 1;
                if (need > 1) begin
                    load_state = LOAD_CONT;
                end else begin
                    store_partial();
                    load_state = (b == SEP_BYTE) ? LOAD_LEAD : LOAD_SKIP;
                end
            end
        endfunction

        // Work out the glyph that a lookup selects.
        function t_glyph_result resolve(bit [31:0] q);
            int unsigned   n;
            int unsigned   span;
            int unsigned   idx;
            bit [31:0]     value;
            bit            hit;
            t_glyph_result r;
            n     = lead_length(q[7:0]);
            value = '0;
            for (int i = 0; i < n; i++) value = (value << 8) | q[8*i +: 8];
            span = glyph_span();
            idx  = 0;
            hit  = 1'b0;
            if (table_on) begin
                for (int i = 0; i < span; i++) begin
                    if (!hit && entry_valid[i] && entry_value[i] == value) begin
                        idx = i;
                        hit = 1'b1;
                    end
                end
            end else if (value > 32 && value <= 127) begin
                idx = value;
                hit = 1'b1;
            end
            r.present  = (idx < span);
            r.fallback = !hit;
            r.index    = idx[8:0];
            r.offset   = r.present ? 17'(glyph_bytes * idx) : 17'd0;
            r.used     = n[2:0];
            lookups++;
            if (hit) hits++;
            if (!r.present) absent++;
            return r;
        endfunction

        // Note an accepted command.
        function void take_command(logic [1:0] cmd, logic [7:0] tbyte, logic [31:0] q);
            case (cmd)
                CMD_TABLE_BYTE: absorb_byte(tbyte);
                CMD_RESTART:    clear_entries();
                CMD_LOOKUP:     pending_glyphs.push_back(resolve(q));
                default: ;
            endcase
        endfunction

        // Pick a filled slot inside the glyph limit, or -1 when there is none.
        function int pick_slot(bit near_top);
            int unsigned range;
            int unsigned window;
            range = (fill_index < glyph_span()) ? fill_index : glyph_span();
            if (range == 0) return -1;
            if (!near_top) return $urandom_range(0, range - 1);
            window = (range < 8) ? range : 8;
            return range - 1 - $urandom_range(0, window - 1);
        endfunction

        // Compare one result with the oldest one due.
        function void check_glyph(logic present, logic fallback, logic [8:0] index,
                                  logic [16:0] offset, logic [2:0] used);
            t_glyph_result got;
            t_glyph_result want;
            got = {present, fallback, index, offset, used};
            if (pending_glyphs.size() == 0) begin
                $display("%0t: unexpected result present=%0d fallback=%0d index=%0d offset=%0d used=%0d",
                         $time, present, fallback, index, offset, used);
                mismatches++;
            end else begin
                want = pending_glyphs.pop_front();
                if (got !== want) begin
                    $display("%0t: result mismatch: expected present=%0d fallback=%0d index=%0d offset=%0d used=%0d",
                             $time, want.present, want.fallback, want.index, want.offset,
                             want.used);
                    $display("%0t:                   actual present=%0d fallback=%0d index=%0d offset=%0d used=%0d",
                             $time, present, fallback, index, offset, used);
                    mismatches++;
                end
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n       = 1'b0;
    logic        start         = 1'b0;
    logic        busy;
    logic [1:0]  i_command     = CMD_TABLE_BYTE;
    logic [7:0]  i_table_byte  = '0;
    logic [31:0] i_query_bytes = '0;
    logic        o_valid;
    logic        o_present;
    logic        o_fallback;
    logic [8:0]  o_glyph_id;
    logic [16:0] o_glyph_offset;
    logic [2:0]  o_bytes_used;
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [3:0]  paddr         = '0;
    logic [31:0] pwdata        = '0;
    logic [31:0] prdata;
    logic        pready;

    glyph_table_tracker tracker;
    t_idle_mode         idle_mode = IDLE_NONE;
    int unsigned        items_sent;
    int unsigned        phases_run;
    int unsigned        cycle_count;

    bitmap_font_glyph_lookup u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_command     (i_command),
        .i_table_byte  (i_table_byte),
        .i_query_bytes (i_query_bytes),
        .o_valid       (o_valid),
        .o_present     (o_present),
        .o_fallback    (o_fallback),
        .o_glyph_id    (o_glyph_id),
        .o_glyph_offset(o_glyph_offset),
        .o_bytes_used  (o_bytes_used),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results still due", $time,
                     tracker.pending_glyphs.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    // Results are taken at the edge that closes their strobe cycle.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            tracker.check_glyph(o_present, o_fallback, o_glyph_id, o_glyph_offset,
                                o_bytes_used);
        end
    end

    // Idle cycles after a transaction: each cycle the sender rests with the mode's odds.
    function automatic int idle_gap();
        int pct;
        int gap;
        pct = (idle_mode == IDLE_SENDER) ? 46 : (idle_mode == IDLE_BOTH) ? 6 : 0;
        gap = 0;
        while (($urandom_range(0, 99) < pct) && (gap < 40)) gap++;
        return gap;
    endfunction

    // Present one command and hold it until the block takes it.
    task automatic send_item(input logic [1:0] cmd, input logic [7:0] tbyte,
                             input logic [31:0] q);
        int gap;
        i_command     <= cmd;
        i_table_byte  <= tbyte;
        i_query_bytes <= q;
        start         <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        tracker.take_command(cmd, tbyte, q);
        items_sent++;
        gap = idle_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_table(input logic [7:0] b);
        send_item(CMD_TABLE_BYTE, b, $urandom);
    endtask

    task automatic send_lookup(input logic [31:0] q);
        send_item(CMD_LOOKUP, 8'($urandom), q);
    endtask

    // APB write: setup cycle, then access cycle until pready.
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        tracker.set_register(idx, value);
    endtask

    // Let every due result arrive and the block go quiet.
    task automatic settle();
        start <= 1'b0;
        @(posedge i_clk);
        while (tracker.pending_glyphs.size() != 0) @(posedge i_clk);
        while (busy) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // One glyph description: a UTF-8 value, some trailing bytes, usually a separator.
    task automatic send_description();
        int         kind;
        int         n;
        int         extras;
        logic [7:0] lead;
        kind = $urandom_range(0, 9);
        n    = 1;
        if (kind <= 6) begin
            n = $urandom_range(1, 4);
            case (n)
                1:       lead = 8'($urandom_range(0, 127));
                2:       lead = 8'hC0 | 8'($urandom_range(0, 31));
                3:       lead = 8'hE0 | 8'($urandom_range(0, 15));
                default: lead = 8'hF0 | 8'($urandom_range(0, 7));
            endcase
        end else if (kind <= 8) begin
            lead = $urandom_range(0, 1) ? 8'($urandom_range(8'h80, 8'hBF))
                                        : 8'($urandom_range(8'hF8, 8'hFE));
        end else begin
            lead = SEP_BYTE;
        end
        send_table(lead);
        // Continuation bytes are mostly well formed, now and then anything.
        for (int i = 1; i < n; i++) begin
            send_table(($urandom_range(0, 7) == 0) ? 8'($urandom)
                                                   : 8'h80 | 8'($urandom_range(0, 63)));
        end
        if (lead != SEP_BYTE) begin
            extras = $urandom_range(0, 3);
            for (int i = 0; i < extras; i++) send_table(8'($urandom_range(0, 254)));
            // A missing separator now and then swallows the next description.
            if ($urandom_range(0, 19) != 0) send_table(SEP_BYTE);
        end
    endtask

    // Lookup that mostly targets a loaded entry, else random or ASCII-range.
    task automatic send_random_lookup();
        logic [31:0] q;
        logic [31:0] v;
        int          slot;
        int          n;
        q    = $urandom;
        slot = -1;
        if ($urandom_range(0, 99) < 65) slot = tracker.pick_slot($urandom_range(0, 1));
        if (slot >= 0) begin
            v = tracker.entry_value[slot];
            n = (v > 32'hFFFFFF) ? 4 : (v > 32'hFFFF) ? 3 : (v > 32'hFF) ? 2 : 1;
            for (int i = 0; i < n; i++) q[8*i +: 8] = 8'(v >> (8 * (n - 1 - i)));
        end else if ($urandom_range(0, 1)) begin
            q[7:0] = 8'($urandom_range(0, 128));
        end
        send_lookup(q);
    endtask

    // Reprogram the font registers, then run a random command mix.
    task automatic run_phase(input logic [9:0] gc, input logic [8:0] gb, input logic on,
                             input t_idle_mode mode, input int count, input int lookup_pct,
                             input int restart_pct, input int prefill);
        int unsigned goal;
        int          roll;
        settle();
        write_reg(REG_GLYPH_COUNT, 32'(gc));
        write_reg(REG_GLYPH_BYTES, 32'(gb));
        write_reg(REG_TABLE_ON, 32'(on));
        idle_mode = mode;
        goal      = items_sent + count;
        phases_run++;
        // A deep table: single-byte separator entries fill most slots.
        if (prefill > 0) begin
            send_item(CMD_RESTART, 8'($urandom), $urandom);
            for (int i = 0; i < prefill; i++) send_table(SEP_BYTE);
        end
        while (items_sent < goal) begin
            roll = $urandom_range(0, 99);
            if (roll < lookup_pct) begin
                send_random_lookup();
            end else if (roll < lookup_pct + restart_pct) begin
                send_item(CMD_RESTART, 8'($urandom), $urandom);
            end else if (roll < lookup_pct + restart_pct + 2) begin
                send_item(CMD_UNUSED, 8'($urandom), $urandom);
            end else if (roll < lookup_pct + restart_pct + 6) begin
                send_table(8'($urandom));
            end else begin
                send_description();
            end
        end
    endtask

    // Main sequence.
    initial begin
        tracker = new();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part on the reset register values.
        send_table(8'h41);
        send_table(SEP_BYTE);
        // A description that opens with the separator ends at once.
        send_table(SEP_BYTE);
        send_table(8'hC3);
        send_table(8'hA9);
        send_table(8'h20);
        send_table(SEP_BYTE);
        send_table(8'hF0);
        send_table(8'h9F);
        send_table(8'h98);
        send_table(8'h80);
        send_table(SEP_BYTE);
        // A separator inside a value is taken as a continuation byte.
        send_table(8'hE2);
        send_table(8'h82);
        send_table(SEP_BYTE);
        send_table(SEP_BYTE);
        // Stray continuation byte as a lead is a one-byte value.
        send_table(8'h80);
        send_table(SEP_BYTE);
        send_lookup(32'hA5A5_5A41);
        send_lookup(32'h0000_00FF);
        send_lookup(32'hFFFF_A9C3);
        send_lookup(32'h8098_9FF0);
        send_lookup(32'h00FF_82E2);
        send_lookup(32'hFFFF_FF80);
        send_item(CMD_UNUSED, 8'hFF, 32'hFFFF_FFFF);
        send_item(CMD_RESTART, 8'h00, 32'h0000_0000);
        send_lookup(32'h0000_0041);

        // Random phases over a spread of register settings.
        run_phase(10'd256, 9'd32, 1'b1, IDLE_NONE, 120, 40, 3, 0);
        run_phase(10'd3, 9'd1, 1'b1, IDLE_SENDER, 100, 35, 3, 0);
        run_phase(10'd0, 9'd511, 1'b1, IDLE_BOTH, 40, 40, 3, 0);
        run_phase(10'd1023, 9'd256, 1'b0, IDLE_SENDER, 120, 60, 3, 0);
        run_phase(10'd100, 9'd0, 1'b0, IDLE_BOTH, 80, 60, 3, 0);
        run_phase(10'd512, 9'd511, 1'b1, IDLE_NONE, 580, 25, 0, 500);
        run_phase(10'd600, 9'd1, 1'b1, IDLE_SENDER, 90, 40, 3, 0);
        run_phase(10'd1, 9'd255, 1'b1, IDLE_BOTH, 40, 40, 3, 0);

        settle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Ran %0d commands over %0d register settings plus the directed part.",
                 items_sent, phases_run);
        $display("Checked %0d lookups: %0d matched, %0d beyond the glyph limit; %0d mismatches.",
                 tracker.lookups, tracker.hits, tracker.absent, tracker.mismatches);
        if (tracker.mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
